// ===== rtl/gqfs_pkg.sv =====
// Shared types, constants and saturating arithmetic helpers for the
// Gaussian quadratic form scorer. No dependencies.
package gqfs_pkg;

  localparam int CODEBOOKS = 256;
  localparam int FIRST_DIM = 32;
  localparam int MAX_DIM   = 48;
  localparam int QDEPTH    = 2;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_SCORE = 2'd2;

  localparam logic [1:0] SEL_MATRIX = 2'd0;
  localparam logic [1:0] SEL_LINEAR = 2'd1;
  localparam logic [1:0] SEL_CONST  = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [1:0]         table_select;
    logic [7:0]         codebook_index;
    logic [9:0]         word_index;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic [7:0]         codebook_out;
    logic signed [63:0] first_score;
    logic signed [63:0] second_score;
  } result_t;

  typedef enum logic [2:0] {
    OP_WR_MAT,
    OP_WR_LIN,
    OP_WR_CST,
    OP_WR_FEAT,
    OP_SCORE
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [7:0]         cb;
    logic [9:0]         wi;
    logic signed [31:0] value;
  } entry_t;

  // Queue handshake toward the back end.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
    if (a == {1'b1, 63'd0}) begin
      return {1'b0, {63{1'b1}}};
    end
    return -a;
  endfunction

endpackage

// ===== rtl/gaussian_quadratic_form_score.sv =====
// Top level of the full-covariance Gaussian quadratic scorer.
// Depends on gqfs_pkg, gqfs_front, gqfs_back (and gqfs_ram below it).
//
// Usage:
//   Drive item_i and raise start; the item transfers at a rising edge where
//   start is high and busy is low. busy rises only while the two-entry
//   command queue is full. Mode 0 writes a model word, mode 1 loads a
//   feature element, mode 2 scores a codebook; out-of-range items are
//   dropped at the front and never reach the queue.
//   A score result shows on result_o for exactly one cycle with done_o high;
//   the receiver cannot stall it and must take it in that cycle.
//   A write lands in its store when it leaves the queue, which it does only
//   while the back end is idle; behind a running score it waits until that
//   score ends. In the back end a score walks the packed matrix words of each
//   row, one matrix word per cycle through the single multiply-accumulate,
//   then per row drains the pipeline and applies the linear term, the
//   two-part row product, rounding and accumulation.
//   The front keeps taking items while a score runs, until the queue fills.
//   cfg_we_i writes total_dim; write it only while the block is idle.
//   Reset clears the queue, the sequencer and sets total_dim to 48; stored
//   model words and features are undefined until written.
module gaussian_quadratic_form_score #(
  parameter int CODEBOOKS = gqfs_pkg::CODEBOOKS,
  parameter int FIRST_DIM = gqfs_pkg::FIRST_DIM,
  parameter int MAX_DIM   = gqfs_pkg::MAX_DIM
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  gqfs_pkg::item_t   item_i,
  input  logic              cfg_we_i,
  input  logic [5:0]        cfg_wdata_i,
  output logic              done_o,
  output gqfs_pkg::result_t result_o
);

  logic [5:0]       total_dim_q;
  gqfs_pkg::queue_t queue;
  logic             pop;

  // Hold the dimension count; it feeds the back end's row limits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_dim_q <= 6'd48;
    end else if (cfg_we_i) begin
      total_dim_q <= cfg_wdata_i;
    end
  end

  gqfs_front #(
    .CODEBOOKS(CODEBOOKS), .FIRST_DIM(FIRST_DIM), .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i, .rst_ni, .start, .busy, .item_i,
    .queue_o(queue), .pop_i(pop)
  );

  gqfs_back #(
    .CODEBOOKS(CODEBOOKS), .FIRST_DIM(FIRST_DIM), .MAX_DIM(MAX_DIM)
  ) u_back (
    .clk_i, .rst_ni, .total_dim_i(total_dim_q),
    .queue_i(queue), .pop_o(pop), .done_o, .result_o
  );

endmodule

// ===== rtl/gqfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gqfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/gqfs_front.sv =====
// Front end: accepts items, drops out-of-range ones, queues the rest.
// Depends on gqfs_pkg.
module gqfs_front #(
  parameter int CODEBOOKS = gqfs_pkg::CODEBOOKS,
  parameter int FIRST_DIM = gqfs_pkg::FIRST_DIM,
  parameter int MAX_DIM   = gqfs_pkg::MAX_DIM
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  gqfs_pkg::item_t item_i,
  output gqfs_pkg::queue_t queue_o,
  input  logic            pop_i
);

  localparam int BLK1   = (FIRST_DIM < MAX_DIM) ? FIRST_DIM : MAX_DIM;
  localparam int BLK2   = MAX_DIM - BLK1;
  localparam int STRIDE = BLK1 * (BLK1 + 1) / 2 + BLK2 * (BLK2 + 1) / 2;
  localparam int QD     = gqfs_pkg::QDEPTH;
  localparam int PW     = $clog2(QD);
  localparam int CW     = $clog2(QD + 1);

  gqfs_pkg::entry_t slot_q [QD];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          keep;
  logic          push;
  gqfs_pkg::entry_t ent;

  // Classify: map mode/select to an operation and check ranges.
  always_comb begin
    ent.cb    = item_i.codebook_index;
    ent.wi    = item_i.word_index;
    ent.value = item_i.value;
    ent.op    = gqfs_pkg::OP_SCORE;
    keep      = 1'b0;
    case (item_i.mode)
      gqfs_pkg::MODE_WRITE: begin
        if (32'(item_i.codebook_index) < CODEBOOKS) begin
          case (item_i.table_select)
            gqfs_pkg::SEL_MATRIX: begin
              ent.op = gqfs_pkg::OP_WR_MAT;
              keep   = 32'(item_i.word_index) < STRIDE;
            end
            gqfs_pkg::SEL_LINEAR: begin
              ent.op = gqfs_pkg::OP_WR_LIN;
              keep   = 32'(item_i.word_index) < MAX_DIM;
            end
            gqfs_pkg::SEL_CONST: begin
              ent.op = gqfs_pkg::OP_WR_CST;
              keep   = item_i.word_index < 10'd2;
            end
            default: keep = 1'b0;
          endcase
        end
      end
      gqfs_pkg::MODE_LOAD: begin
        ent.op = gqfs_pkg::OP_WR_FEAT;
        keep   = 32'(item_i.word_index) < MAX_DIM;
      end
      gqfs_pkg::MODE_SCORE: begin
        ent.op = gqfs_pkg::OP_SCORE;
        keep   = 32'(item_i.codebook_index) < CODEBOOKS;
      end
      default: keep = 1'b0;
    endcase
  end

  assign busy = (cnt_q == CW'(QD));
  assign push = start && !busy && keep;
  assign queue_o.valid = (cnt_q != '0);
  assign queue_o.entry = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (32'(wr_q) == QD - 1) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (32'(rd_q) == QD - 1) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(push) - CW'(pop_i);
    end
  end

endmodule

// ===== rtl/gqfs_back.sv =====
// Back end: executes queued writes and walks one score through a shared
// multiply-accumulate. Depends on gqfs_pkg and gqfs_ram.
module gqfs_back #(
  parameter int CODEBOOKS = gqfs_pkg::CODEBOOKS,
  parameter int FIRST_DIM = gqfs_pkg::FIRST_DIM,
  parameter int MAX_DIM   = gqfs_pkg::MAX_DIM
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [5:0]        total_dim_i,
  input  gqfs_pkg::queue_t  queue_i,
  output logic              pop_o,
  output logic              done_o,
  output gqfs_pkg::result_t result_o
);

  localparam int BLK1   = (FIRST_DIM < MAX_DIM) ? FIRST_DIM : MAX_DIM;
  localparam int BLK2   = MAX_DIM - BLK1;
  localparam int TRI1   = BLK1 * (BLK1 + 1) / 2;
  localparam int STRIDE = TRI1 + BLK2 * (BLK2 + 1) / 2;
  localparam int MDEPTH = CODEBOOKS * STRIDE;
  localparam int LDEPTH = CODEBOOKS * MAX_DIM;
  localparam int CDEPTH = CODEBOOKS * 2;
  localparam int MAW    = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
  localparam int LAW    = $clog2(LDEPTH);
  localparam int CAW    = $clog2(CDEPTH);
  localparam int FAW    = $clog2(MAX_DIM);
  localparam int DW     = $clog2(MAX_DIM + 1);
  localparam int IW     = $clog2(STRIDE + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_BASE, S_BLK, S_CST, S_INNER, S_DRAIN, S_LIN,
    S_MLO, S_MHI, S_SUM, S_SHF, S_ACC, S_BEND, S_OUT
  } state_e;

  state_e state_q;
  logic [7:0]      cb_q;
  logic [MAW-1:0]  mat_base_q;
  logic [LAW-1:0]  lin_base_q;
  logic            blk_q;
  logic [DW-1:0]   l_q, m_q, hi_q;
  logic [IW-1:0]   idx_q;
  logic            v1_q, v2_q;
  logic signed [63:0] prod_q, rest_q, acc_q, s1_q, q_q;
  logic signed [64:0] plo_q;
  logic signed [63:0] phi_q;
  logic signed [95:0] p96_q;

  gqfs_pkg::entry_t e;
  logic [DW-1:0]  d, lo, hi;
  logic [MAW-1:0] mat_waddr, mat_raddr;
  logic [LAW-1:0] lin_waddr, lin_raddr;
  logic [CAW-1:0] cst_waddr, cst_raddr;
  logic [31:0]    mat_rdata, lin_rdata, cst_rdata, fa_rdata, fb_rdata;
  logic           we_mat, we_lin, we_cst, we_feat;
  logic signed [31:0] xl, bl;
  logic signed [79:0] shifted;

  assign e     = queue_i.entry;
  assign pop_o = queue_i.valid && (state_q == S_IDLE);

  assign we_mat  = pop_o && (e.op == gqfs_pkg::OP_WR_MAT);
  assign we_lin  = pop_o && (e.op == gqfs_pkg::OP_WR_LIN);
  assign we_cst  = pop_o && (e.op == gqfs_pkg::OP_WR_CST);
  assign we_feat = pop_o && (e.op == gqfs_pkg::OP_WR_FEAT);

  assign mat_waddr = MAW'(MAW'(e.cb) * MAW'(STRIDE) + MAW'(e.wi));
  assign lin_waddr = LAW'(LAW'(e.cb) * LAW'(MAX_DIM) + LAW'(e.wi));
  assign cst_waddr = CAW'({CAW'(e.cb), e.wi[0]});
  assign mat_raddr = MAW'(mat_base_q + MAW'(idx_q));
  assign lin_raddr = LAW'(lin_base_q + LAW'(l_q));
  assign cst_raddr = CAW'({CAW'(cb_q), blk_q});

  // Clamp the dimension count and derive the current block's row range.
  always_comb begin
    d  = (32'(total_dim_i) < MAX_DIM) ? DW'(total_dim_i) : DW'(MAX_DIM);
    lo = blk_q ? DW'(BLK1) : '0;
    if (blk_q) begin
      hi = (d > DW'(BLK1)) ? d : DW'(BLK1);
    end else begin
      hi = (d < DW'(BLK1)) ? d : DW'(BLK1);
    end
  end

  gqfs_ram #(.WIDTH(32), .DEPTH(MDEPTH)) u_mat (
    .clk_i, .we_i(we_mat), .waddr_i(mat_waddr), .wdata_i(e.value),
    .raddr_i(mat_raddr), .rdata_o(mat_rdata));
  gqfs_ram #(.WIDTH(32), .DEPTH(LDEPTH)) u_lin (
    .clk_i, .we_i(we_lin), .waddr_i(lin_waddr), .wdata_i(e.value),
    .raddr_i(lin_raddr), .rdata_o(lin_rdata));
  gqfs_ram #(.WIDTH(32), .DEPTH(CDEPTH)) u_cst (
    .clk_i, .we_i(we_cst), .waddr_i(cst_waddr), .wdata_i(e.value),
    .raddr_i(cst_raddr), .rdata_o(cst_rdata));
  // Two copies of the feature vector: one for x_m, one for x_l.
  gqfs_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_fa (
    .clk_i, .we_i(we_feat), .waddr_i(e.wi[FAW-1:0]), .wdata_i(e.value),
    .raddr_i(m_q[FAW-1:0]), .rdata_o(fa_rdata));
  gqfs_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_fb (
    .clk_i, .we_i(we_feat), .waddr_i(e.wi[FAW-1:0]), .wdata_i(e.value),
    .raddr_i(l_q[FAW-1:0]), .rdata_o(fb_rdata));

  // Row operands stay valid: l is held for the whole row.
  assign xl = $signed(fb_rdata);
  assign bl = $signed(lin_rdata);
  assign shifted = p96_q[95:16];

  // Element pipeline: read, multiply, accumulate.
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_q <= $signed(mat_rdata) * $signed(fa_rdata);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      done_o     <= 1'b0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      blk_q      <= 1'b0;
      cb_q       <= '0;
      l_q        <= '0;
      m_q        <= '0;
      hi_q       <= '0;
      idx_q      <= '0;
      mat_base_q <= '0;
      lin_base_q <= '0;
      result_o   <= '0;
      rest_q     <= '0;
      acc_q      <= '0;
      s1_q       <= '0;
      q_q        <= '0;
      plo_q      <= '0;
      phi_q      <= '0;
      p96_q      <= '0;
    end else begin
      done_o <= 1'b0;
      v1_q   <= (state_q == S_INNER);
      v2_q   <= v1_q;
      if (v2_q) begin
        rest_q <= gqfs_pkg::sat_add(rest_q, prod_q);
      end
      case (state_q)
        S_IDLE: begin
          if (pop_o && (e.op == gqfs_pkg::OP_SCORE)) begin
            cb_q    <= e.cb;
            state_q <= S_BASE;
          end
        end
        S_BASE: begin
          mat_base_q <= MAW'(MAW'(cb_q) * MAW'(STRIDE));
          lin_base_q <= LAW'(LAW'(cb_q) * LAW'(MAX_DIM));
          blk_q      <= 1'b0;
          state_q    <= S_BLK;
        end
        S_BLK: begin
          l_q     <= lo;
          m_q     <= lo;
          hi_q    <= hi;
          idx_q   <= blk_q ? IW'(TRI1) : '0;
          state_q <= S_CST;
        end
        S_CST: begin
          acc_q   <= {{16{cst_rdata[31]}}, cst_rdata, 16'd0};
          rest_q  <= '0;
          state_q <= (l_q >= hi_q) ? S_BEND : S_INNER;
        end
        S_INNER: begin
          idx_q <= idx_q + 1'b1;
          if (m_q == l_q) begin
            state_q <= S_DRAIN;
          end else begin
            m_q <= m_q + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!v1_q && !v2_q) begin
            state_q <= S_LIN;
          end
        end
        S_LIN: begin
          rest_q  <= gqfs_pkg::sat_add(rest_q, -{{16{bl[31]}}, bl, 16'd0});
          state_q <= S_MLO;
        end
        S_MLO: begin
          plo_q   <= $signed({1'b0, rest_q[31:0]}) * xl;
          state_q <= S_MHI;
        end
        S_MHI: begin
          phi_q   <= $signed(rest_q[63:32]) * xl;
          state_q <= S_SUM;
        end
        S_SUM: begin
          p96_q   <= {phi_q, 32'd0} + {{31{plo_q[64]}}, plo_q};
          state_q <= S_SHF;
        end
        S_SHF: begin
          // Arithmetic shift floors; clamp what no longer fits 64 bits.
          if (shifted[79:63] != {17{shifted[79]}}) begin
            q_q <= shifted[79] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          end else begin
            q_q <= shifted[63:0];
          end
          state_q <= S_ACC;
        end
        S_ACC: begin
          acc_q  <= gqfs_pkg::sat_add(acc_q, q_q);
          rest_q <= '0;
          l_q    <= l_q + 1'b1;
          m_q    <= lo;
          state_q <= (l_q + 1'b1 >= hi_q) ? S_BEND : S_INNER;
        end
        S_BEND: begin
          if (!blk_q) begin
            s1_q    <= acc_q;
            blk_q   <= 1'b1;
            state_q <= S_BLK;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          done_o                <= 1'b1;
          result_o.codebook_out <= cb_q;
          result_o.first_score  <= gqfs_pkg::sat_neg(s1_q);
          result_o.second_score <= gqfs_pkg::sat_neg(acc_q);
          state_q               <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_inner_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INNER) |-> (m_q <= l_q && l_q < hi_q))
    else $error("column walk left the current row");
  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIN) |-> (!v1_q && !v2_q))
    else $error("row finished with products still in flight");

endmodule

// ===== tb/sv/gaussian_quadratic_form_score_tb.sv =====
// Self-checking testbench for the Gaussian quadratic form scorer.
// Depends on gqfs_pkg and gaussian_quadratic_form_score.
`timescale 1ns / 1ps

module gaussian_quadratic_form_score_tb;

  localparam int FIRST_DIM = gqfs_pkg::FIRST_DIM;
  localparam int MAX_DIM   = gqfs_pkg::MAX_DIM;
  localparam int TRI1    = FIRST_DIM * (FIRST_DIM + 1) / 2;
  localparam int BLK2    = MAX_DIM - FIRST_DIM;
  localparam int STRIDE  = TRI1 + BLK2 * (BLK2 + 1) / 2;
  localparam int NCB     = 1;          // codebooks kept fully written
  localparam longint LIMIT = 64'd4000000;
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, 63'd0};

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  gqfs_pkg::item_t   item_i = '0;
  logic    cfg_we_i = 1'b0;
  logic [5:0] cfg_wdata_i = 6'd48;
  logic    done_o;
  gqfs_pkg::result_t result_o;

  gaussian_quadratic_form_score uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i), .done_o(done_o),
    .result_o(result_o)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the block's stores and its dimension register.
  logic signed [31:0] mat_m [NCB][STRIDE];
  logic signed [31:0] lin_m [NCB][MAX_DIM];
  logic signed [63:0] cst_m [NCB][2];
  logic signed [31:0] feat_m [MAX_DIM];
  int unsigned dim_m = 48;

  gqfs_pkg::item_t   pending_items[$];
  gqfs_pkg::result_t score_queue[$];
  int      mismatches = 0;
  int      scores_seen = 0;
  longint  cycles = 0;
  logic    drain_req = 1'b0;   // driver holds off until scores drain
  logic    cfg_req = 1'b0;
  logic [5:0] cfg_val;

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  // Floor of (r * x) / 2^16, clamped to 64 bits.
  function automatic logic signed [63:0] row_times_x(logic signed [63:0] r,
                                                     logic signed [31:0] x);
    logic signed [95:0] p;
    logic signed [95:0] q;
    p = 96'(r) * 96'(x);
    q = p >>> 16;
    if (q > 96'(S64_MAX)) return S64_MAX;
    if (q < 96'(S64_MIN)) return S64_MIN;
    return q[63:0];
  endfunction

  function automatic logic signed [63:0] block_sum(int cb, int lo, int hi, int base,
                                                   logic signed [63:0] acc);
    int idx;
    logic signed [63:0] rest;
    idx = base;
    for (int l = lo; l < hi; l++) begin
      rest = 0;
      for (int m = lo; m <= l; m++) begin
        rest = add_sat(rest, 64'(mat_m[cb][idx]) * 64'(feat_m[m]));
        idx++;
      end
      rest = add_sat(rest, -(64'(lin_m[cb][l]) <<< 16));
      acc = add_sat(acc, row_times_x(rest, feat_m[l]));
    end
    return acc;
  endfunction

  function automatic logic signed [63:0] neg_sat(logic signed [63:0] v);
    return (v == S64_MIN) ? S64_MAX : -v;
  endfunction

  // Update the shadow state for one transfer and queue any score it causes.
  task automatic predict_item(gqfs_pkg::item_t it);
    int d;
    int d1;
    gqfs_pkg::result_t r;
    case (it.mode)
      gqfs_pkg::MODE_WRITE: begin
        if (it.codebook_index < NCB) begin
          if (it.table_select == gqfs_pkg::SEL_MATRIX && it.word_index < STRIDE)
            mat_m[it.codebook_index][it.word_index] = it.value;
          else if (it.table_select == gqfs_pkg::SEL_LINEAR && it.word_index < MAX_DIM)
            lin_m[it.codebook_index][it.word_index] = it.value;
          else if (it.table_select == gqfs_pkg::SEL_CONST && it.word_index < 2)
            cst_m[it.codebook_index][it.word_index] = 64'(it.value) <<< 16;
        end
      end
      gqfs_pkg::MODE_LOAD: if (it.word_index < MAX_DIM) feat_m[it.word_index] = it.value;
      gqfs_pkg::MODE_SCORE: begin
        d = dim_m < MAX_DIM ? int'(dim_m) : MAX_DIM;
        d1 = d < FIRST_DIM ? d : FIRST_DIM;
        r.codebook_out = it.codebook_index;
        r.first_score = neg_sat(block_sum(int'(it.codebook_index), 0, d1, 0,
                                          cst_m[it.codebook_index][0]));
        r.second_score = neg_sat(block_sum(int'(it.codebook_index), FIRST_DIM,
                                           d > FIRST_DIM ? d : FIRST_DIM, TRI1,
                                           cst_m[it.codebook_index][1]));
        score_queue.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Driver: present queued items, advance on transfer, insert random gaps.
  int gap = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    cfg_we_i <= rst_ni && cfg_req && !(start && busy);
    if (rst_ni) begin
      if (start && !busy) begin
        predict_item(item_i);
        void'(pending_items.pop_front());
      end
      if (start && busy) begin
        // hold the item until it transfers
      end else if (cfg_req) begin
        start <= 1'b0;
        cfg_wdata_i <= cfg_val;
        dim_m = 32'(cfg_val);
        cfg_req <= 1'b0;
      end else if (drain_req || gap > 0 || pending_items.size() == 0) begin
        start <= 1'b0;
        if (gap > 0) gap <= gap - 1;
      end else if (start && !busy) begin
        // just transferred: pick the next item or a gap
        if ($urandom_range(0, 3) == 0) begin
          start <= 1'b0;
          gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                             : $urandom_range(1, 3);
        end else begin
          item_i <= pending_items[0];
          start <= 1'b1;
        end
      end else begin
        item_i <= pending_items[0];
        start <= 1'b1;
      end
    end
  end

  // Monitor: each strobed result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      scores_seen <= scores_seen + 1;
      if (score_queue.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result cb=%0d", result_o.codebook_out);
      end else begin
        if (result_o !== score_queue[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp cb=%0d %h %h, got cb=%0d %h %h",
                     score_queue[0].codebook_out, score_queue[0].first_score,
                     score_queue[0].second_score, result_o.codebook_out,
                     result_o.first_score, result_o.second_score);
        end
        void'(score_queue.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic gqfs_pkg::item_t mk(logic [1:0] mo, logic [1:0] sel, logic [7:0] cb,
                                         logic [9:0] wi, logic [31:0] v);
    gqfs_pkg::item_t it;
    it.mode = mo; it.table_select = sel; it.codebook_index = cb;
    it.word_index = wi; it.value = v;
    return it;
  endfunction

  // Values with mostly small magnitude, sometimes extremes.
  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      default: return 32'($signed($urandom_range(0, 262143)) - 131072);
    endcase
  endfunction

  task automatic wait_idle();
    while (pending_items.size() != 0 || start) @(posedge clk_i);
    while (score_queue.size() != 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
  endtask

  task automatic set_dim(logic [5:0] d);
    wait_idle();
    cfg_val = d;
    cfg_req = 1'b1;
    @(posedge clk_i);
    while (cfg_req) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Fill every model store of the used codebooks, and the features.
  task automatic fill_all(bit extreme);
    for (int c = 0; c < NCB; c++) begin
      for (int w = 0; w < STRIDE; w++)
        pending_items.push_back(mk(gqfs_pkg::MODE_WRITE, gqfs_pkg::SEL_MATRIX, 8'(c),
                                   10'(w), extreme ? 32'h7fffffff : rnd_val()));
      for (int w = 0; w < MAX_DIM; w++)
        pending_items.push_back(mk(gqfs_pkg::MODE_WRITE, gqfs_pkg::SEL_LINEAR, 8'(c),
                                   10'(w), extreme ? 32'h80000000 : rnd_val()));
      for (int w = 0; w < 2; w++)
        pending_items.push_back(mk(gqfs_pkg::MODE_WRITE, gqfs_pkg::SEL_CONST, 8'(c),
                                   10'(w), rnd_val()));
    end
    for (int w = 0; w < MAX_DIM; w++)
      pending_items.push_back(mk(gqfs_pkg::MODE_LOAD, 2'd0, 8'd0, 10'(w),
                                 extreme ? (w[0] ? 32'h80000000 : 32'h7fffffff)
                                         : rnd_val()));
  endtask

  task automatic score_some(int n);
    for (int i = 0; i < n; i++)
      pending_items.push_back(mk(gqfs_pkg::MODE_SCORE, 2'd0,
                                 8'($urandom_range(0, NCB - 1)), 10'd0, 32'd0));
  endtask

  // Random mix: rewrites, feature reloads, scores, ignored items and mode 3.
  task automatic random_mix(int n);
    gqfs_pkg::item_t it;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: it = mk(gqfs_pkg::MODE_WRITE, 2'($urandom_range(0, 2)),
                         8'($urandom_range(0, NCB - 1)),
                         10'($urandom_range(0, STRIDE - 1)), rnd_val());
        3, 4: it = mk(gqfs_pkg::MODE_LOAD, 2'($urandom()), 8'($urandom()),
                      10'($urandom_range(0, MAX_DIM - 1)), rnd_val());
        5, 6: it = mk(gqfs_pkg::MODE_SCORE, 2'($urandom()),
                      8'($urandom_range(0, NCB - 1)), 10'($urandom()), $urandom());
        7: it = mk(gqfs_pkg::MODE_WRITE, 2'($urandom()), 8'($urandom_range(NCB, 255)),
                   10'($urandom()), $urandom());
        8: it = mk(2'd3, 2'($urandom()), 8'($urandom()), 10'($urandom()), $urandom());
        default: it = mk(gqfs_pkg::MODE_LOAD, 2'($urandom()), 8'($urandom()),
                         10'($urandom_range(MAX_DIM, 1023)), $urandom());
      endcase
      if (it.mode == gqfs_pkg::MODE_WRITE && it.table_select == gqfs_pkg::SEL_LINEAR)
        it.word_index = 10'(it.word_index % MAX_DIM);
      if (it.mode == gqfs_pkg::MODE_WRITE && it.table_select == gqfs_pkg::SEL_CONST)
        it.word_index = 10'(it.word_index % 2);
      pending_items.push_back(it);
    end
  endtask

  logic [5:0] dims [6] = '{6'd48, 6'd33, 6'd40, 6'd63, 6'd32, 6'd5};

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: full model fill, a score, items that must be dropped, then a score.
    fill_all(1'b0);
    score_some(1);
    pending_items.push_back(mk(gqfs_pkg::MODE_WRITE, gqfs_pkg::SEL_MATRIX, 8'd0,
                               10'h3ff, 32'd0));
    pending_items.push_back(mk(gqfs_pkg::MODE_WRITE, 2'd3, 8'd0, 10'd0, 32'd0));
    pending_items.push_back(mk(gqfs_pkg::MODE_LOAD, 2'd0, 8'd0, 10'h3ff, 32'd0));
    pending_items.push_back(mk(2'd3, 2'd3, 8'hff, 10'h3ff, 32'hffffffff));
    score_some(1);
    wait_idle();
    for (int p = 0; p < 6; p++) begin
      set_dim(dims[p]);
      score_some(2);
      random_mix(12);
      // let most items go, then pause until all scores are back
      while (pending_items.size() > 6) @(posedge clk_i);
      drain_req = 1'b1;
      while (score_queue.size() != 0 || start) @(posedge clk_i);
      drain_req = 1'b0;
    end
    wait_idle();
    $display("covered %0d scores over %0d dimension settings", scores_seen, 6);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/gqfs_pkg.sv
rtl/gqfs_ram.sv
rtl/gqfs_front.sv
rtl/gqfs_back.sv
rtl/gaussian_quadratic_form_score.sv
tb/sv/gaussian_quadratic_form_score_tb.sv
